FILE: rtl/link_bond_round_robin_selector_top_macros.svh
// Assertion macros shared by the link bond selector modules
`ifndef LINK_BOND_ROUND_ROBIN_SELECTOR_TOP_MACROS_SVH
`define LINK_BOND_ROUND_ROBIN_SELECTOR_TOP_MACROS_SVH

// Check that cond holds at every clock edge outside reset
`define LBRR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that cons holds in the same cycle as ante
`define LBRR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define LBRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lbrr_pkg.sv
// Types and constants of the link bond round-robin selector
package lbrr_pkg;

	localparam int PORT_W   = 4;
	localparam int MASK_W   = 16;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 4;
	localparam int FUNC_W   = 2;
	localparam int NUM_PORTS = 16;

	localparam logic [FUNC_W-1:0] FUNC_TX      = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENSLAVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_MEMBERS  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NO_LINK     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_REFUSED     = 3'd6;

	typedef struct packed {
		logic load_in;
		logic walk_init;
		logic walk_step;
		logic commit;
	} lbrr_cmd_t;

	typedef struct packed {
		logic walk_needed;
		logic finish;
	} lbrr_sts_t;

endpackage

FILE: rtl/link_bond_round_robin_selector_top.sv
// Top level of the link bond round-robin selector
//
// Channel  Dir  tdata                                        tuser
// s_       in   port[3:0] up[4] running[5] mask[21:6]        func[1:0]
// m_       out  status[2:0] out_port[6:3] sent[7] count[11:8] -
//
// One request at a time. Enslave, release, close and a transmit on an empty
// table commit from the execute state once the result slot is free.
// A transmit visits k table entries (1 to the member count), one a cycle, and
// commits from the walk state once it finds a live link or reaches the last entry.
// A result waiting on m_tready holds the final commit and so blocks the next one.
// Reset empties the table, clears all marks and the round-robin position.
module link_bond_round_robin_selector_top #(
	parameter int MAX_MEMBERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // port, port_up, port_running, link_ok_mask, zero pad
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status, out_port, sent, member_count, zero pad
);
	import lbrr_pkg::*;

	lbrr_cmd_t cmd;
	lbrr_sts_t sts;

	logic [STATUS_W-1:0] res_status;
	logic [PORT_W-1:0]   res_out_port;
	logic                res_sent;
	logic [COUNT_W-1:0]  res_member_count;

	lbrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lbrr_dp #(
		.MAX_MEMBERS (MAX_MEMBERS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_func          (s_tuser),
		.in_port          (s_tdata[3:0]),
		.in_port_up       (s_tdata[4]),
		.in_port_running  (s_tdata[5]),
		.in_link_ok_mask  (s_tdata[21:6]),
		.res_status       (res_status),
		.res_out_port     (res_out_port),
		.res_sent         (res_sent),
		.res_member_count (res_member_count)
	);

	assign m_tdata = {4'b0000, res_member_count, res_sent, res_out_port, res_status};

endmodule

FILE: rtl/lbrr_dp.sv
// Datapath: request registers, member table, round-robin walk and result register
module lbrr_dp #(
	parameter int MAX_MEMBERS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbrr_pkg::lbrr_cmd_t                 cmd,
	output lbrr_pkg::lbrr_sts_t                 sts,
	input  logic [lbrr_pkg::FUNC_W-1:0]         in_func,
	input  logic [lbrr_pkg::PORT_W-1:0]         in_port,
	input  logic                                in_port_up,
	input  logic                                in_port_running,
	input  logic [lbrr_pkg::MASK_W-1:0]         in_link_ok_mask,
	output logic [lbrr_pkg::STATUS_W-1:0]       res_status,
	output logic [lbrr_pkg::PORT_W-1:0]         res_out_port,
	output logic                                res_sent,
	output logic [lbrr_pkg::COUNT_W-1:0]        res_member_count
);
	import lbrr_pkg::*;

	localparam int IDX_W = $clog2(MAX_MEMBERS);
	localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

	logic [FUNC_W-1:0]   func_q;
	logic [PORT_W-1:0]   port_q;
	logic                up_q;
	logic                run_q;
	logic [MASK_W-1:0]   mask_q;

	logic [PORT_W-1:0]   table_q [MAX_MEMBERS];
	logic [CNT_W-1:0]    total_q;
	logic [IDX_W-1:0]    rr_q;
	logic [NUM_PORTS-1:0] marks_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    cnt_q;

	logic [PORT_W-1:0]   cur_port;
	logic                hit;
	logic                last;
	logic [IDX_W-1:0]    idx_wrap;

	logic [STATUS_W-1:0] status_nxt;
	logic [PORT_W-1:0]   out_port_nxt;
	logic                sent_nxt;
	logic [CNT_W-1:0]    total_nxt;
	logic [IDX_W-1:0]    rr_nxt;
	logic [NUM_PORTS-1:0] marks_nxt;
	logic                tbl_we;

	assign cur_port = table_q[idx_q];
	assign hit      = mask_q[cur_port];
	assign last     = (CNT_W'(cnt_q) == total_q - CNT_W'(1));
	assign idx_wrap = (CNT_W'(idx_q) == total_q - CNT_W'(1)) ? '0 : idx_q + IDX_W'(1);

	assign sts.walk_needed = (func_q == FUNC_TX) && (total_q != '0);
	assign sts.finish      = hit || last;

	always_comb begin
		status_nxt   = ST_OK;
		out_port_nxt = '0;
		sent_nxt     = 1'b0;
		total_nxt    = total_q;
		rr_nxt       = rr_q;
		marks_nxt    = marks_q;
		tbl_we       = 1'b0;
		case (func_q)
			FUNC_TX: begin
				if (total_q == '0) begin
					status_nxt = ST_NO_MEMBERS;
				end else if (hit) begin
					out_port_nxt = cur_port;
					sent_nxt     = 1'b1;
					rr_nxt       = idx_wrap;
				end else begin
					status_nxt = ST_NO_LINK;
				end
			end
			FUNC_ENSLAVE: begin
				if (int'(port_q) >= NUM_PORTS || !up_q || !run_q) begin
					status_nxt = ST_NOT_RUNNING;
				end else if (marks_q[port_q]) begin
					status_nxt = ST_BUSY;
				end else if (total_q >= CNT_W'(MAX_MEMBERS)) begin
					status_nxt = ST_FULL;
				end else begin
					if (total_q == '0) begin
						rr_nxt = '0;
					end
					tbl_we            = 1'b1;
					total_nxt         = total_q + CNT_W'(1);
					marks_nxt[port_q] = 1'b1;
				end
			end
			FUNC_RELEASE: begin
				status_nxt = ST_REFUSED;
			end
			default: begin
				total_nxt = '0;
				rr_nxt    = '0;
				marks_nxt = '0;
			end
		endcase
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			port_q <= in_port;
			up_q   <= in_port_up;
			run_q  <= in_port_running;
			mask_q <= in_link_ok_mask;
		end
	end

	// append to the member table
	always_ff @(posedge clk) begin
		if (cmd.commit && tbl_we) begin
			table_q[total_q[IDX_W-1:0]] <= port_q;
		end
	end

	// advance the walk
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			idx_q <= rr_q;
			cnt_q <= '0;
		end else if (cmd.walk_step) begin
			idx_q <= idx_wrap;
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			rr_q    <= '0;
			marks_q <= '0;
		end else if (cmd.commit) begin
			total_q <= total_nxt;
			rr_q    <= rr_nxt;
			marks_q <= marks_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status       <= status_nxt;
			res_out_port     <= out_port_nxt;
			res_sent         <= sent_nxt;
			res_member_count <= COUNT_W'(total_nxt);
		end
	end

	`include "link_bond_round_robin_selector_top_macros.svh"

	`LBRR_ASSERT_ALWAYS(a_total_bound, total_q <= CNT_W'(MAX_MEMBERS), "member total over limit")
	`LBRR_ASSERT_ALWAYS(a_marks_match, $countones(marks_q) == int'(total_q), "marks disagree with total")
	`LBRR_ASSERT_SAME(a_walk_in_range, cmd.walk_step, CNT_W'(idx_q) < total_q, "walk index out of table")

endmodule

FILE: rtl/lbrr_ctrl.sv
// Controller: request sequencing, walk control and result valid flag
module lbrr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lbrr_pkg::lbrr_cmd_t  cmd,
	input  lbrr_pkg::lbrr_sts_t  sts
);
	import lbrr_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt     = state_q;
		cmd.load_in   = 1'b0;
		cmd.walk_init = 1'b0;
		cmd.walk_step = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.walk_needed) begin
					cmd.walk_init = 1'b1;
					state_nxt     = S_WALK;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			S_WALK: begin
				if (!sts.finish) begin
					cmd.walk_step = 1'b1;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`include "link_bond_round_robin_selector_top_macros.svh"

	`LBRR_ASSERT_SAME(a_commit_slot, cmd.commit, slot_free, "result overwritten before taken")
	`LBRR_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid_q, "result lost after commit")
	`LBRR_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_q == S_EXEC, "request not taken up")

endmodule

FILE: tb/link_bond_round_robin_selector_top_tb.sv
// Self-checking testbench: directed and random requests against a round-robin bond predictor
`timescale 1ns / 100ps

module link_bond_round_robin_selector_top_tb;

	import lbrr_pkg::*;

	localparam int BOND_SIZE   = 8;
	localparam int PHASE_ITEMS = 400;
	localparam int DRAIN_WAIT  = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PORT_W-1:0] port;
		logic              up;
		logic              running;
		logic [MASK_W-1:0] mask;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PORT_W-1:0]   out_port;
		logic                sent;
		logic [COUNT_W-1:0]  count;
	} result_t;

	typedef struct packed {
		req_t    rq;
		logic    typed;
		result_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // port, port_up, port_running, link_ok_mask, zero pad
	logic [1:0]  s_tuser = '0;  // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // status, out_port, sent, member_count, zero pad

	logic [PORT_W-1:0] bond_ports [BOND_SIZE];
	int unsigned       bond_total = 0;
	int unsigned       rr_pos = 0;
	logic [MASK_W-1:0] bond_marks = '0;

	result_t pending_results [$];
	int      mismatches = 0;
	int      n_requests = 0;
	int      n_results = 0;
	int      n_forwarded = 0;
	int      n_dropped = 0;
	int      n_full = 0;
	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;
	int      hold_asked = 0;
	int      hold_taken = 0;
	int      hold_left = 0;
	int      cycles = 0;
	row_t    plan [25];

	link_bond_round_robin_selector_top #(
		.MAX_MEMBERS(BOND_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic result_t bond_decide(input req_t rq);
		result_t     r;
		int unsigned idx;
		logic        found;
		r = '0;
		found = 1'b0;
		case (rq.func)
			FUNC_TX: begin
				if (bond_total == 0) begin
					r.status = ST_NO_MEMBERS;
				end else begin
					for (int i = 0; i < bond_total; i++) begin
						idx = (rr_pos + i) % bond_total;
						if (!found && rq.mask[bond_ports[idx]]) begin
							found = 1'b1;
							rr_pos = (idx + 1) % bond_total;
							r.out_port = bond_ports[idx];
							r.sent = 1'b1;
						end
					end
					r.status = found ? ST_OK : ST_NO_LINK;
				end
			end
			FUNC_ENSLAVE: begin
				if (rq.port >= NUM_PORTS || !rq.up || !rq.running) begin
					r.status = ST_NOT_RUNNING;
				end else if (bond_marks[rq.port]) begin
					r.status = ST_BUSY;
				end else if (bond_total >= BOND_SIZE) begin
					r.status = ST_FULL;
				end else begin
					if (bond_total == 0)
						rr_pos = 0;
					bond_ports[bond_total] = rq.port;
					bond_total++;
					bond_marks[rq.port] = 1'b1;
					r.status = ST_OK;
				end
			end
			FUNC_RELEASE: begin
				r.status = ST_REFUSED;
			end
			default: begin
				bond_total = 0;
				rr_pos = 0;
				bond_marks = '0;
				r.status = ST_OK;
			end
		endcase
		r.count = bond_total[COUNT_W-1:0];
		return r;
	endfunction

	function automatic row_t mk_row(input logic [FUNC_W-1:0] func, input int port,
			input logic up, input logic running, input logic [MASK_W-1:0] mask,
			input logic typed, input logic [STATUS_W-1:0] status, input int out_port,
			input logic sent, input int count);
		row_t w;
		w.rq = '{func: func, port: port[PORT_W-1:0], up: up, running: running, mask: mask};
		w.typed = typed;
		w.res = '{status: status, out_port: out_port[PORT_W-1:0], sent: sent,
			count: count[COUNT_W-1:0]};
		return w;
	endfunction

	function automatic req_t random_request();
		req_t rq;
		int   sel;
		rq = req_t'({$urandom, $urandom});
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			rq.func = FUNC_TX;
			case ($urandom_range(0, 9))
				0: rq.mask = '0;
				1: rq.mask = '1;
				2, 3, 4: rq.mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
				5: rq.mask = (MASK_W'(1) << $urandom_range(0, MASK_W - 1)) |
					(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
				default: rq.mask = MASK_W'($urandom);
			endcase
		end else if (sel < 82) begin
			rq.func = FUNC_ENSLAVE;
			if ($urandom_range(0, 99) < 85) begin
				rq.up = 1'b1;
				rq.running = 1'b1;
			end
		end else if (sel < 88) begin
			rq.func = FUNC_RELEASE;
		end else if (sel < 93) begin
			rq.func = FUNC_CLOSE;
		end
		return rq;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic send_request(input req_t rq, input logic typed, input result_t want);
		result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.func;
		s_tdata <= {2'b00, rq.mask, rq.running, rq.up, rq.port};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = bond_decide(rq);
		pending_results.push_back(typed ? want : predicted);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{status: m_tdata[2:0], out_port: m_tdata[6:3], sent: m_tdata[7],
				count: m_tdata[11:8]};
			n_results++;
			if (got.sent)
				n_forwarded++;
			if (got.status == ST_NO_LINK || got.status == ST_NO_MEMBERS)
				n_dropped++;
			if (got.status == ST_FULL)
				n_full++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending, expected none, actual %h",
					$time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, got.status);
				compare_field("out_port", want.out_port, got.out_port);
				compare_field("sent", want.sent, got.sent);
				compare_field("member_count", want.count, got.count);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("link_bond_round_robin_selector_top_tb failed");
			$finish;
		end
	end

	initial begin
		plan = '{
			mk_row(FUNC_TX,      0, 0, 0, 16'h0000, 1, ST_NO_MEMBERS,  0, 0, 0),
			mk_row(FUNC_RELEASE, 3, 1, 1, 16'h0000, 1, ST_REFUSED,     0, 0, 0),
			mk_row(FUNC_ENSLAVE, 0, 0, 1, 16'h0000, 1, ST_NOT_RUNNING, 0, 0, 0),
			mk_row(FUNC_ENSLAVE, 0, 1, 0, 16'h0000, 1, ST_NOT_RUNNING, 0, 0, 0),
			mk_row(FUNC_ENSLAVE, 0, 1, 1, 16'h0000, 1, ST_OK,          0, 0, 1),
			mk_row(FUNC_ENSLAVE, 0, 1, 1, 16'h0000, 1, ST_BUSY,        0, 0, 1),
			mk_row(FUNC_ENSLAVE, 15, 1, 1, 16'h0000, 1, ST_OK,         0, 0, 2),
			mk_row(FUNC_TX,      0, 0, 0, 16'h0000, 1, ST_NO_LINK,     0, 0, 2),
			mk_row(FUNC_TX,      0, 0, 0, 16'hFFFF, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_TX,      0, 0, 0, 16'hFFFF, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_ENSLAVE, 3, 1, 1, 16'h0000, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_ENSLAVE, 5, 1, 1, 16'h0000, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_ENSLAVE, 7, 1, 1, 16'h0000, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_ENSLAVE, 9, 1, 1, 16'h0000, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_ENSLAVE, 11, 1, 1, 16'h0000, 0, ST_OK,         0, 0, 0),
			mk_row(FUNC_ENSLAVE, 12, 1, 1, 16'h0000, 0, ST_OK,         0, 0, 0),
			mk_row(FUNC_ENSLAVE, 13, 1, 1, 16'h0000, 1, ST_FULL,       0, 0, 8),
			mk_row(FUNC_ENSLAVE, 0, 1, 1, 16'h0000, 1, ST_BUSY,        0, 0, 8),
			mk_row(FUNC_ENSLAVE, 13, 0, 1, 16'h0000, 1, ST_NOT_RUNNING, 0, 0, 8),
			mk_row(FUNC_TX,      0, 0, 0, 16'h1000, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_TX,      0, 0, 0, 16'h8001, 0, ST_OK,          0, 0, 0),
			mk_row(FUNC_RELEASE, 9, 1, 1, 16'h0000, 1, ST_REFUSED,     0, 0, 8),
			mk_row(FUNC_CLOSE,   0, 0, 0, 16'h0000, 1, ST_OK,          0, 0, 0),
			mk_row(FUNC_TX,      0, 0, 0, 16'hFFFF, 1, ST_NO_MEMBERS,  0, 0, 0),
			mk_row(FUNC_ENSLAVE, 8, 1, 1, 16'h0000, 1, ST_OK,          0, 0, 1)
		};
		tx_idle_pct = 14;
		rx_stall_pct = 52;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_request(plan[i].rq, plan[i].typed, plan[i].res);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 52 : 0;
			rx_stall_pct = (ph == 0) ? 52 : (ph == 1) ? 14 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 150)
					hold_asked++;
				if (ph == 1 && n == 200)
					wait_drained();
				send_request(random_request(), 1'b0, '0);
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Covered %0d requests and %0d results: %0d packets forwarded, %0d dropped,",
			n_requests, n_results, n_forwarded, n_dropped);
		$display("%0d enslave attempts on a full table, %0d mismatches.", n_full, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("link_bond_round_robin_selector_top_tb passed");
		end else begin
			$display("link_bond_round_robin_selector_top_tb failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lbrr_pkg.sv
rtl/lbrr_dp.sv
rtl/lbrr_ctrl.sv
rtl/link_bond_round_robin_selector_top.sv
tb/link_bond_round_robin_selector_top_tb.sv
